// ===== sv/masked_byte_pattern_scanner_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the masked byte pattern scanner
// Short forms for the concurrent checks used in the scanner's RTL.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MBPS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scanner check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define MBPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scanner check failed: next-cycle implication");

`endif

// ===== sv/mbps_pkg.sv =====
// ----------------------------------------------------------------------------
// Scanner package
// Fixed widths, register indexes and the result beat type.
// ----------------------------------------------------------------------------
package mbps_pkg;

  // Number of pattern byte slots held by the two pattern registers.
  localparam int PATTERN_SLOTS = 16;
  localparam int LEN_W         = 5;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int OFFSET_OUT_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_ALL   = 3'd4;

  typedef struct packed {
    logic [OFFSET_OUT_W-1:0] match_offset;
    logic                    is_match;
    logic                    is_done;
    logic                    any_found;
  } result_t;

endpackage

// ===== sv/mbps_cell.sv =====
// ----------------------------------------------------------------------------
// Window cell
// Holds one window byte, passes it on to the next cell and compares the
// byte it is about to take against its aligned pattern byte.
// ----------------------------------------------------------------------------
module mbps_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] byte_in,
  input  logic [7:0] pat_byte,
  input  logic       cmp_en,
  output logic [7:0] byte_q,
  output logic       hit
);

  // A cell outside the pattern or at a wildcard position always agrees.
  assign hit = !cmp_en || (byte_in == pat_byte);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_q <= byte_in;
    end
  end

endmodule

// ===== sv/mbps_out_buf.sv =====
// ----------------------------------------------------------------------------
// Result buffer
// Output register with one skid entry so the scan keeps going while a
// result beat waits for the consumer.
// ----------------------------------------------------------------------------
module mbps_out_buf
  import mbps_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t res_in,
  output logic    can_accept,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res_out
);

  logic    skid_valid;
  result_t skid;
  logic    drain;

  assign drain      = !out_valid || out_ready;
  assign can_accept = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid) begin
        res_out <= skid;
        if (push) begin
          skid <= res_in;
        end
      end else if (push) begin
        res_out <= res_in;
      end
    end else if (push) begin
      skid <= res_in;
    end
  end

endmodule

// ===== sv/masked_byte_pattern_scanner.sv =====
// ----------------------------------------------------------------------------
// Masked byte pattern scanner: takes one byte per cycle while the output
// buffer can accept; the cell row compares in parallel and combinationally,
// and each result beat waits in an output register plus one skid entry.
// Synchronous reset restores the configuration defaults and clears the offset count and found flag.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  // Configuration write port
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // Input beats: one byte of the scanned region each
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              data_byte,
  input  logic                    region_end,
  // Result beats
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [OFFSET_OUT_W-1:0] match_offset,
  output logic                    is_match,
  output logic                    is_done,
  output logic                    any_found
);

`include "masked_byte_pattern_scanner_macros.svh"

  // Only the first min(MAX_PATTERN, 16) bytes of the pattern can be used.
  localparam int CAP = (MAX_PATTERN < PATTERN_SLOTS) ? MAX_PATTERN : PATTERN_SLOTS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [PATTERN_SLOTS-1:0] care_mask;
  logic [LEN_W-1:0]      pattern_length;
  logic                  report_all;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= '1;
      pattern_length <= LEN_W'(1);
      report_all     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_LOW:  pattern_low    <= cfg_data;
        CFG_PATTERN_HIGH: pattern_high   <= cfg_data;
        CFG_CARE_MASK:    care_mask      <= cfg_data[PATTERN_SLOTS-1:0];
        CFG_PATTERN_LEN:  pattern_length <= cfg_data[LEN_W-1:0];
        CFG_REPORT_ALL:   report_all     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A length of zero behaves as one, and anything past the cell capacity is
  // clipped to it.
  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] len_m1;

  always_comb begin
    if (pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (pattern_length > LEN_W'(CAP)) begin
      eff_len = LEN_W'(CAP);
    end else begin
      eff_len = pattern_length;
    end
    len_m1 = eff_len - LEN_W'(1);
  end

  // All pattern bytes side by side; byte i sits at bits 8i+7:8i.
  logic [2*CFG_DATA_W-1:0] pattern_all;
  assign pattern_all = {pattern_high, pattern_low};

  // --------------------------------------------------------------------------
  // Handshake and region state
  // --------------------------------------------------------------------------
  logic in_fire;
  logic buf_can_accept;

  assign in_ready = buf_can_accept;
  assign in_fire  = in_valid && in_ready;

  logic [OFFSET_BITS-1:0] bytes_seen;
  logic                   found_flag;

  // --------------------------------------------------------------------------
  // Row of window cells. Cell k holds the byte that arrived k beats ago.
  // Once the new byte shifts in, cell k lines up with pattern byte
  // len-1-k, so every cell compares the byte it is about to take in. The
  // whole row answers in the same cycle the byte is accepted.
  // --------------------------------------------------------------------------
  logic [7:0]             win_q   [MAX_PATTERN];
  logic [7:0]             win_in  [MAX_PATTERN];
  logic [7:0]             cell_pat[MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_cmp;
  logic [MAX_PATTERN-1:0] cell_hit;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign win_in[k] = data_byte;
    end else begin : g_link
      assign win_in[k] = win_q[k-1];
    end

    if (k < PATTERN_SLOTS) begin : g_slot
      logic [LEN_W-1:0] pidx;
      assign pidx        = len_m1 - LEN_W'(k);
      assign cell_pat[k] = pattern_all[8*pidx[3:0] +: 8];
      assign cell_cmp[k] = (eff_len > LEN_W'(k)) && care_mask[pidx[3:0]];
    end else begin : g_spare
      assign cell_pat[k] = '0;
      assign cell_cmp[k] = 1'b0;
    end

    mbps_cell u_cell (
      .clk      (clk),
      .shift_en (in_fire),
      .byte_in  (win_in[k]),
      .pat_byte (cell_pat[k]),
      .cmp_en   (cell_cmp[k]),
      .byte_q   (win_q[k]),
      .hit      (cell_hit[k])
    );
  end

  // --------------------------------------------------------------------------
  // Match decision. A hit needs pattern-length bytes of the current region,
  // which also keeps bytes of an earlier region out of the compare.
  // --------------------------------------------------------------------------
  logic [OFFSET_BITS-1:0] len_m1_ext;
  logic [OFFSET_BITS-1:0] start_pos;
  logic                   hit;
  logic                   report;
  logic                   has_result;
  logic                   found_now;

  assign len_m1_ext = OFFSET_BITS'(len_m1);
  assign start_pos  = bytes_seen - len_m1_ext;
  assign hit        = (&cell_hit) && (bytes_seen >= len_m1_ext);
  assign report     = hit && (report_all || !found_flag);
  assign found_now  = found_flag || hit;
  assign has_result = report || region_end;

  // The offset counter stops at its all-ones value; a region end starts the
  // next region at zero with the found flag cleared.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      found_flag <= 1'b0;
    end else if (in_fire) begin
      if (region_end) begin
        bytes_seen <= '0;
        found_flag <= 1'b0;
      end else begin
        if (bytes_seen != '1) begin
          bytes_seen <= bytes_seen + OFFSET_BITS'(1);
        end
        found_flag <= found_now;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result beat, handed to the output buffer
  // --------------------------------------------------------------------------
  logic [OFFSET_OUT_W-1:0] start_out;

  if (OFFSET_BITS >= OFFSET_OUT_W) begin : g_off_trunc
    assign start_out = start_pos[OFFSET_OUT_W-1:0];
  end else begin : g_off_ext
    assign start_out = OFFSET_OUT_W'(start_pos);
  end

  result_t res_new;
  result_t res_out;

  always_comb begin
    res_new.match_offset = report ? start_out : '0;
    res_new.is_match     = report;
    res_new.is_done      = region_end;
    res_new.any_found    = region_end && found_now;
  end

  mbps_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (in_fire && has_result),
    .res_in     (res_new),
    .can_accept (buf_can_accept),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res_out    (res_out)
  );

  assign match_offset = res_out.match_offset;
  assign is_match     = res_out.is_match;
  assign is_done      = res_out.is_done;
  assign any_found    = res_out.any_found;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // A region end leaves the offset count and found flag cleared.
  `MBPS_ASSERT_NEXT(a_region_restart, clk, rst, in_fire && region_end, (bytes_seen == '0) && !found_flag)
  // any_found is only ever reported on the completion beat.
  `MBPS_ASSERT_SAME(a_found_on_done, clk, rst, out_valid && any_found, is_done)
  // A beat without a match carries a zero offset.
  `MBPS_ASSERT_SAME(a_offset_zero, clk, rst, out_valid && !is_match, match_offset == '0)
  // A match on a byte that is not a region end always marks the region as having a match.
  `MBPS_ASSERT_NEXT(a_match_sets_flag, clk, rst, in_fire && hit && !region_end, found_flag)

endmodule

// ===== test/scan_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan result checker
// Watches the configuration port and both beat channels of the masked byte
// pattern scanner, predicts the result beat, if any, of every accepted byte and
// compares each accepted result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module scan_result_checker
  import mbps_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [7:0]              data_byte,
  input  logic                    region_end,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [OFFSET_OUT_W-1:0] match_offset,
  input  logic                    is_match,
  input  logic                    is_done,
  input  logic                    any_found,
  output int                      mismatches,
  output int                      pending
);

  // Window depth follows the default MAX_PATTERN of the scanner.
  localparam int WINDOW = 16;

  logic [63:0]      pat_low;
  logic [63:0]      pat_high;
  logic [15:0]      care;
  logic [LEN_W-1:0] len_reg;
  logic             every_match;

  logic [7:0]  window [WINDOW];
  logic [31:0] seen;
  logic        found;

  result_t expected_results [$];

  // Shifts one region byte into the window and queues the result it causes.
  task automatic predict_scan_step(input logic [7:0] b, input logic last);
    logic [127:0] pat_all;
    int           len;
    logic         hit;
    logic         report;
    logic [31:0]  start;
    result_t      r;
    pat_all = {pat_high, pat_low};
    len = (len_reg == 0) ? 1 : (len_reg > WINDOW) ? WINDOW : int'(len_reg);
    for (int k = WINDOW - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = b;
    hit = 1'b0;
    start = '0;
    if (seen >= len - 1) begin
      hit = 1'b1;
      for (int i = 0; i < len; i++) begin
        if (care[i] && window[len-1-i] != pat_all[8*i +: 8]) hit = 1'b0;
      end
      start = seen - (len - 1);
    end
    report = hit && (every_match || !found);
    if (hit) found = 1'b1;
    if (seen != '1) seen = seen + 1;
    if (report || last) begin
      r.match_offset = report ? start : '0;
      r.is_match     = report;
      r.is_done      = last;
      r.any_found    = last && found;
      expected_results = {expected_results, r};
    end
    if (last) begin
      seen  = '0;
      found = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      pat_low     = '0;
      pat_high    = '0;
      care        = 16'hFFFF;
      len_reg     = LEN_W'(1);
      every_match = 1'b0;
      for (int k = 0; k < WINDOW; k++) window[k] = '0;
      seen        = '0;
      found       = 1'b0;
      expected_results.delete();
      mismatches <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PATTERN_LOW:  pat_low     = cfg_data;
          CFG_PATTERN_HIGH: pat_high    = cfg_data;
          CFG_CARE_MASK:    care        = cfg_data[15:0];
          CFG_PATTERN_LEN:  len_reg     = cfg_data[LEN_W-1:0];
          CFG_REPORT_ALL:   every_match = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_scan_step(data_byte, region_end);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat: offset %0d match %b done %b found %b",
                   $time, match_offset, is_match, is_done, any_found);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          if (match_offset !== want.match_offset || is_match !== want.is_match ||
              is_done !== want.is_done || any_found !== want.any_found) begin
            $display("%0t: result mismatch: expected offset %0d match %b done %b found %b",
                     $time, want.match_offset, want.is_match, want.is_done,
                     want.any_found);
            $display("%0t:                  actual   offset %0d match %b done %b found %b",
                     $time, match_offset, is_match, is_done, any_found);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ===== test/masked_byte_pattern_scanner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte pattern scanner testbench
// Streams directed and random regions through the scanner under several
// pattern settings and idling mixes; the result checker predicts and
// compares every result beat, and this module gives the verdict.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_tb;
  import mbps_pkg::*;

  // A long receiver hold-off; the block must fill up and stall its input.
  localparam int HOLD_CYCLES   = 200;
  // Cycles without any accepted beat before the run is declared hung. The
  // longest legal quiet stretch comes from the hold-off above.
  localparam int STALL_LIMIT   = 2000;
  // Covers the output register plus a skid entry that may still hold a beat.
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_BEATS   = 100;
  localparam int PRESSURE_BEATS = 60;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [7:0]              data_byte;
  logic                    region_end;
  logic                    out_valid;
  logic                    out_ready;
  logic [OFFSET_OUT_W-1:0] match_offset;
  logic                    is_match;
  logic                    is_done;
  logic                    any_found;

  int mismatches;
  int pending;

  // Idling mix, in percent of cycles, one for the sender and one for the receiver.
  int send_idle_pct;
  int recv_stall_pct;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_req;

  // Stimulus-side copy of the pattern, used only to build regions that hit.
  logic [7:0]  pat [16];
  logic [15:0] pat_care;
  int          pat_len;
  int          phase_beats;

  masked_byte_pattern_scanner DUT (
    .clk, .rst,
    .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .data_byte, .region_end,
    .out_valid, .out_ready, .match_offset, .is_match, .is_done, .any_found
  );

  scan_result_checker u_result_check (
    .clk, .rst,
    .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .data_byte, .region_end,
    .out_valid, .out_ready, .match_offset, .is_match, .is_done, .any_found,
    .mismatches, .pending
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: stalls at random at the chosen rate, and on request holds off
  // for a fixed, self-counted stretch while the sender keeps offering beats.
  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: ends the run if no beat moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Register write: one cycle with the write enable high.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Writes every register. The narrow registers get random upper bits so
  // that the scanner is seen to use only the bits it owns.
  task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [15:0] mask, input logic [4:0] len,
                              input logic every);
    write_reg(CFG_PATTERN_LOW, lo);
    write_reg(CFG_PATTERN_HIGH, hi);
    write_reg(CFG_CARE_MASK, {$urandom, 16'($urandom), mask});
    write_reg(CFG_PATTERN_LEN, {$urandom, 27'($urandom), len});
    write_reg(CFG_REPORT_ALL, {$urandom, 31'($urandom), every});
    for (int i = 0; i < 8; i++) begin
      pat[i]   = lo[8*i +: 8];
      pat[i+8] = hi[8*i +: 8];
    end
    pat_care = mask;
    pat_len  = (len == 0) ? 1 : (len > 16) ? 16 : int'(len);
  endtask

  // Offers one beat and returns at the rising edge where it is accepted.
  // Valid is only lowered in idle cycles, so it never drops between beats
  // that go out back to back.
  task automatic send_beat(input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    region_end <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Builds a region from bytes of the pattern and random bytes, then plants
  // up to three copies of the pattern at random starts, which may overlap.
  // One region in ten is pure noise with nothing planted.
  task automatic send_random_region();
    logic [7:0] region_bytes [0:95];
    int         size;
    int         copies;
    int         at;
    bit         noise;
    size  = ($urandom_range(9) == 0) ? $urandom_range(41, 96) : $urandom_range(1, 40);
    noise = ($urandom_range(9) == 0);
    for (int i = 0; i < size; i++) begin
      region_bytes[i] = (noise || $urandom_range(2) == 0) ? 8'($urandom)
                                                          : pat[$urandom_range(pat_len - 1)];
    end
    copies = noise ? 0 : $urandom_range(3);
    for (int c = 0; c < copies; c++) begin
      if (size >= pat_len) begin
        at = $urandom_range(size - pat_len);
        for (int i = 0; i < pat_len; i++)
          region_bytes[at + i] = pat_care[i] ? pat[i] : 8'($urandom);
      end
    end
    for (int i = 0; i < size; i++) send_beat(region_bytes[i], i == size - 1);
    phase_beats += size;
  endtask

  // Pauses the sender until every predicted result has come out, then lets
  // the pipeline settle, since a byte with no result may still be inside.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [4:0]  len_pick;
    logic [15:0] mask_pick;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    data_byte      = '0;
    region_end     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    pat_len        = 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, no idling. A length register of zero acts as one; in
    // first-only mode the second hit of the region is not reported, but the
    // done beat still says a match was found.
    load_pattern(64'hFF, 64'h0, 16'hFFFF, 5'd0, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);

    // Pattern 00 FF 00 in all mode: overlapping hits at offsets 0 and 2, the
    // second ending on the last byte so one beat carries match and done.
    // Then a region shorter than the pattern, while the window still holds
    // a full match from the region before.
    wait_idle();
    load_pattern(64'h0000_0000_0000_FF00, 64'h0, 16'hFFFF, 5'd3, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);

    // A length above sixteen acts as sixteen. Only the first and the last
    // pattern bytes are compared; everything between is a wildcard.
    wait_idle();
    load_pattern(64'h0, 64'hFF00_0000_0000_0000, 16'h8001, 5'd17, 1'b1);
    send_beat(8'h00, 1'b0);
    for (int i = 0; i < 14; i++) send_beat(8'($urandom), 1'b0);
    send_beat(8'hFF, 1'b1);

    // Back pressure: an all-wildcard single-byte pattern in all mode makes
    // every byte a result beat. The receiver holds off for a long stretch
    // while the sender keeps going, so the scanner must stall its input.
    wait_idle();
    load_pattern({$urandom, $urandom}, {$urandom, $urandom}, 16'h0000, 5'd1, 1'b1);
    hold_req    = 1'b1;
    phase_beats = 0;
    while (phase_beats < PRESSURE_BEATS) send_random_region();

    // Random part: four idling mixes, three pattern settings each. The first
    // two settings of each mix take the shortest and the longest pattern.
    for (int mode = 0; mode < 4; mode++) begin
      for (int setting = 0; setting < 3; setting++) begin
        wait_idle();
        case (mode)
          0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
          2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
          default: begin send_idle_pct = 34; recv_stall_pct = 34; end
        endcase
        len_pick = (setting == 0) ? 5'd1 : (setting == 1) ? 5'd16 : 5'($urandom_range(31));
        case ($urandom_range(3))
          0:       mask_pick = 16'hFFFF;
          1:       mask_pick = 16'h0000;
          default: mask_pick = 16'($urandom);
        endcase
        load_pattern({$urandom, $urandom}, {$urandom, $urandom}, mask_pick, len_pick,
                     1'((mode + setting) % 2));
        phase_beats = 0;
        while (phase_beats < PHASE_BEATS) send_random_region();
      end
    end

    wait_idle();
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/mbps_pkg.sv
sv/mbps_cell.sv
sv/mbps_out_buf.sv
sv/masked_byte_pattern_scanner.sv
test/scan_result_checker.sv
test/masked_byte_pattern_scanner_tb.sv
